/* rtl/sigact_pkg.sv */
package sigact_pkg;

  // command codes
  localparam logic CMD_FWD = 1'b0;
  localparam logic CMD_BWD = 1'b1;

  // fixed-point layout
  localparam int X_W    = 16;
  localparam int RES_W  = 17;
  localparam int S_W    = 16;
  localparam int Q62_W  = 64;

  // exp chain: one squaring constant per bit of |x|
  localparam int EXP_STEPS = 16;
  // restoring division: one quotient bit per stage
  localparam int DIV_STEPS = 17;
  localparam int Q_W       = DIV_STEPS + 1;

  localparam logic [Q62_W-1:0] Q62_ONE = 64'd1 << 62;

  // series for exp(-2^-11), truncated after the fifth-order term
  localparam logic [Q62_W-1:0] TAY1 = Q62_ONE >> 11;
  localparam logic [Q62_W-1:0] TAY2 = (TAY1 >> 11) / 2;
  localparam logic [Q62_W-1:0] TAY3 = (TAY2 >> 11) / 3;
  localparam logic [Q62_W-1:0] TAY4 = (TAY3 >> 11) / 4;
  localparam logic [Q62_W-1:0] TAY5 = (TAY4 >> 11) / 5;
  localparam logic [Q62_W-1:0] EXP_C0 = Q62_ONE - TAY1 + TAY2 - TAY3 + TAY4 - TAY5;

  typedef logic [EXP_STEPS-1:0][Q62_W-1:0] exp_tab_t;

  // q2.62 product, rounded half up (elaboration only)
  function automatic logic [Q62_W-1:0] q62_mul(input logic [Q62_W-1:0] a,
                                               input logic [Q62_W-1:0] b);
    logic [2*Q62_W-1:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62] + {63'd0, p[61]};
  endfunction

  // exp(-2^i / 2048) by repeated squaring
  function automatic exp_tab_t exp_table();
    exp_tab_t c;
    c[0] = EXP_C0;
    for (int i = 1; i < EXP_STEPS; i++) begin
      c[i] = q62_mul(c[i-1], c[i-1]);
    end
    return c;
  endfunction

  localparam exp_tab_t EXP_C = exp_table();

  // per-item side data carried down the pipeline
  typedef struct packed {
    logic                  command;
    logic                  last;
    logic                  x_neg;
    logic [X_W-1:0]        mag;
    logic signed [X_W-1:0] grad;
  } meta_t;

  // finished result
  typedef struct packed {
    logic signed [RES_W-1:0] result_value;
    logic                    last_out;
  } res_t;

  // output buffer status
  typedef struct packed {
    logic full;
    logic empty;
  } obuf_status_t;

endpackage

/* rtl/sigact_in_if.sv */
interface sigact_in_if;
  logic              valid;
  logic              ready;
  logic              command;
  logic signed [15:0] x_value;
  logic signed [15:0] grad_in;
  logic              last_in;

  modport source (output valid, command, x_value, grad_in, last_in, input ready);
  modport sink   (input valid, command, x_value, grad_in, last_in, output ready);
endinterface

/* rtl/sigact_out_if.sv */
interface sigact_out_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] result_value;
  logic               last_out;

  modport source (output valid, result_value, last_out, input ready);
  modport sink   (input valid, result_value, last_out, output ready);
endinterface

/* rtl/sigmoid_activation_fwd_bwd.sv */
// throughput: one item per cycle unless a full output queue stalls the pipeline
// (pipeline: input register, 32 exp stages, 19 divider stages, 3 gradient stages, output queue)
// a two-entry output queue lets the pipeline keep moving while one result waits
// reset: synchronous, clears all valid bits and the queue; no clearing pass
module sigmoid_activation_fwd_bwd (
  input  logic         clk,
  input  logic         rst,
  sigact_in_if.sink    din,
  sigact_out_if.source dout
);
  import sigact_pkg::*;

  logic             en;
  logic             v_in;
  meta_t            m_in;
  logic             e_valid;
  meta_t            e_meta;
  logic [Q62_W-1:0] e_u;
  logic             d_valid;
  meta_t            d_meta;
  logic [S_W-1:0]   d_s;
  logic             g_valid;
  res_t             g_res;
  res_t             ob_res;
  obuf_status_t     ob_st;

  // pipeline moves unless the last stage is held by a full queue
  assign en        = !g_valid || !ob_st.full;
  assign din.ready = en;

  // input register, |x| and signs
  always_ff @(posedge clk) begin
    if (rst) begin
      v_in <= 1'b0;
    end else if (en) begin
      v_in <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_in.command <= din.command;
      m_in.last    <= din.last_in;
      m_in.x_neg   <= din.x_value[X_W-1];
      m_in.mag     <= din.x_value[X_W-1] ? X_W'(-din.x_value) : din.x_value;
      m_in.grad    <= din.grad_in;
    end
  end

  sigact_exp u_exp (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v_in),
    .in_meta   (m_in),
    .out_valid (e_valid),
    .out_meta  (e_meta),
    .out_u     (e_u)
  );

  sigact_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (e_valid),
    .in_meta   (e_meta),
    .in_u      (e_u),
    .out_valid (d_valid),
    .out_meta  (d_meta),
    .out_s     (d_s)
  );

  sigact_grad u_grad (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (d_valid),
    .in_meta   (d_meta),
    .in_s      (d_s),
    .out_valid (g_valid),
    .out_res   (g_res)
  );

  sigact_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (g_valid && en),
    .push_res  (g_res),
    .pop       (dout.valid && dout.ready),
    .out_valid (dout.valid),
    .out_res   (ob_res),
    .status    (ob_st)
  );

  assign dout.result_value = ob_res.result_value;
  assign dout.last_out     = ob_res.last_out;

  // a held last stage keeps its result until the queue takes it
  assert property (@(posedge clk) disable iff (rst)
    (g_valid && !en) |=> (g_valid && $stable(g_res)))
    else $error("last stage result changed while stalled");

  // a result pushed into an empty queue shows at the output next cycle
  assert property (@(posedge clk) disable iff (rst)
    (g_valid && en && ob_st.empty) |=> dout.valid)
    else $error("pushed result missing at output");

  // an accepted item lands in the input register
  assert property (@(posedge clk) disable iff (rst)
    (din.valid && din.ready) |=> v_in)
    else $error("accepted item lost at input register");
endmodule

/* rtl/sigact_exp.sv */
module sigact_exp (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  sigact_pkg::meta_t           in_meta,
  output logic                        out_valid,
  output sigact_pkg::meta_t           out_meta,
  output logic [sigact_pkg::Q62_W-1:0] out_u
);
  import sigact_pkg::*;

  localparam int N = EXP_STEPS;

  // stage a: partial products, stage b: sum and round
  logic [N-1:0]       va;
  logic [N-1:0]       vb;
  logic [N-1:0]       mula;
  meta_t              ma [N];
  meta_t              mb [N];
  logic [Q62_W-1:0]   ua [N];
  logic [Q62_W-1:0]   ub [N];
  logic [63:0]        p00 [N];
  logic [63:0]        p01 [N];
  logic [63:0]        p10 [N];
  logic [63:0]        p11 [N];

  meta_t              sm [N];
  logic [Q62_W-1:0]   su [N];
  logic [127:0]       prod [N];
  logic [Q62_W-1:0]   rnd [N];

  // stage inputs and rounded products
  always_comb begin
    for (int i = 0; i < N; i++) begin
      if (i == 0) begin
        sm[i] = in_meta;
        su[i] = Q62_ONE;
      end else begin
        sm[i] = mb[i-1];
        su[i] = ub[i-1];
      end
      prod[i] = {64'd0, p00[i]} + {32'd0, p01[i], 32'd0} + {32'd0, p10[i], 32'd0}
              + {p11[i], 64'd0};
      rnd[i]  = prod[i][125:62] + {63'd0, prod[i][61]};
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= '0;
      vb <= '0;
    end else if (en) begin
      for (int i = 0; i < N; i++) begin
        va[i] <= (i == 0) ? in_valid : vb[(i == 0) ? 0 : i-1];
      end
      vb <= va;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N; i++) begin
        ma[i]   <= sm[i];
        ua[i]   <= su[i];
        mula[i] <= sm[i].mag[i];
        p00[i]  <= su[i][31:0]  * EXP_C[i][31:0];
        p01[i]  <= su[i][31:0]  * EXP_C[i][63:32];
        p10[i]  <= su[i][63:32] * EXP_C[i][31:0];
        p11[i]  <= su[i][63:32] * EXP_C[i][63:32];
        mb[i]   <= ma[i];
        ub[i]   <= mula[i] ? rnd[i] : ua[i];
      end
    end
  end

  assign out_valid = vb[N-1];
  assign out_meta  = mb[N-1];
  assign out_u     = ub[N-1];
endmodule

/* rtl/sigact_div.sv */
module sigact_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  sigact_pkg::meta_t            in_meta,
  input  logic [sigact_pkg::Q62_W-1:0] in_u,
  output logic                         out_valid,
  output sigact_pkg::meta_t            out_meta,
  output logic [sigact_pkg::S_W-1:0]   out_s
);
  import sigact_pkg::*;

  localparam int N = DIV_STEPS;

  // stage 0 sets up a and d, stages 1..N make one quotient bit each
  logic [N:0]       v;
  meta_t            m [N+1];
  logic [Q62_W-1:0] d [N+1];
  logic [Q62_W-1:0] r [N+1];
  logic [Q_W-1:0]   q [N+1];

  logic [Q62_W-1:0] a0;
  logic [Q62_W-1:0] d0;
  logic             q0;
  logic [Q62_W:0]   r2 [N+1];
  logic [N:0]       ge;

  // rounding stage
  logic             vs;
  meta_t            ms;
  logic [S_W-1:0]   s;
  logic [Q_W:0]     qinc;
  logic [Q_W-1:0]   shalf;

  always_comb begin
    d0 = Q62_ONE + in_u;
    a0 = in_meta.x_neg ? in_u : Q62_ONE;
    q0 = (a0 == d0);
    for (int k = 0; k <= N; k++) begin
      if (k == 0) begin
        r2[k] = '0;
        ge[k] = 1'b0;
      end else begin
        r2[k] = {r[k-1], 1'b0};
        ge[k] = (r2[k] >= {1'b0, d[k-1]});
      end
    end
    qinc  = {1'b0, q[N]} + {{Q_W{1'b0}}, 1'b1};
    shalf = qinc[Q_W:1];
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v  <= '0;
      vs <= 1'b0;
    end else if (en) begin
      v  <= {v[N-1:0], in_valid};
      vs <= v[N];
    end
  end

  // divider datapath
  always_ff @(posedge clk) begin
    if (en) begin
      m[0] <= in_meta;
      d[0] <= d0;
      r[0] <= q0 ? '0 : a0;
      q[0] <= {{(Q_W-1){1'b0}}, q0};
      for (int k = 1; k <= N; k++) begin
        m[k] <= m[k-1];
        d[k] <= d[k-1];
        r[k] <= ge[k] ? Q62_W'(r2[k] - {1'b0, d[k-1]}) : r2[k][Q62_W-1:0];
        q[k] <= {q[k-1][Q_W-2:0], ge[k]};
      end
      ms <= m[N];
      s  <= (shalf[Q_W-1:S_W] != '0) ? {S_W{1'b1}} : shalf[S_W-1:0];
    end
  end

  assign out_valid = vs;
  assign out_meta  = ms;
  assign out_s     = s;
endmodule

/* rtl/sigact_grad.sv */
module sigact_grad (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  sigact_pkg::meta_t          in_meta,
  input  logic [sigact_pkg::S_W-1:0] in_s,
  output logic                       out_valid,
  output sigact_pkg::res_t           out_res
);
  import sigact_pkg::*;

  // stage 1: s*(1-s) and |grad|
  logic             v1;
  logic             cmd1;
  logic             last1;
  logic             neg1;
  logic [S_W-1:0]   s1;
  logic [30:0]      deriv1;
  logic [X_W-1:0]   gm1;
  // stage 2: |grad| * s*(1-s)
  logic             v2;
  logic             cmd2;
  logic             last2;
  logic             neg2;
  logic [S_W-1:0]   s2;
  logic [46:0]      mfull2;
  // stage 3: pass s (forward), or round and sign the gradient (backward)
  logic             v3;
  res_t             res3;

  logic [16:0]      comp;
  logic [32:0]      dprod;
  logic [47:0]      rsum;
  logic [13:0]      mag;
  logic [RES_W-1:0] smag;
  logic [RES_W-1:0] res_next;

  always_comb begin
    comp  = 17'h10000 - {1'b0, in_s};
    dprod = in_s * comp;
    rsum  = {1'b0, mfull2} + 48'h0000_8000_0000;
    mag   = rsum[45:32];
    smag  = {{(RES_W-14){1'b0}}, mag};
    unique case (cmd2)
      CMD_FWD: res_next = {1'b0, s2};
      CMD_BWD: res_next = neg2 ? RES_W'(-smag) : smag;
      default: res_next = '0;
    endcase
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // gradient datapath
  always_ff @(posedge clk) begin
    if (en) begin
      cmd1   <= in_meta.command;
      last1  <= in_meta.last;
      neg1   <= in_meta.grad[X_W-1];
      s1     <= in_s;
      deriv1 <= dprod[30:0];
      gm1    <= in_meta.grad[X_W-1] ? X_W'(-in_meta.grad) : in_meta.grad;
      cmd2   <= cmd1;
      last2  <= last1;
      neg2   <= neg1;
      s2     <= s1;
      mfull2 <= gm1 * deriv1;
      res3.result_value <= res_next;
      res3.last_out     <= last2;
    end
  end

  assign out_valid = v3;
  assign out_res   = res3;
endmodule

/* rtl/sigact_obuf.sv */
module sigact_obuf (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  sigact_pkg::res_t          push_res,
  input  logic                      pop,
  output logic                      out_valid,
  output sigact_pkg::res_t          out_res,
  output sigact_pkg::obuf_status_t  status
);
  import sigact_pkg::*;

  // two-entry result queue
  res_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic [1:0] count_next;

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  // pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count_next;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_res;
    end
  end

  assign out_valid    = (count != 2'd0);
  assign out_res      = mem[rd_ptr];
  assign status.full  = (count == 2'd2);
  assign status.empty = (count == 2'd0);
endmodule
